// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/mh64_pkg.sv =====
// Package for the 64-bit murmur hash unit: constants, state and command types.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package mh64_pkg;

   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;

   localparam logic [2:0] ADDR_HASH_SEED = 3'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DISPATCH,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_POST,
      ST_EMIT
   } state_type;

   // Which product the multiply sequence is working on
   typedef enum logic [2:0] {
      PH_INIT,
      PH_K1,
      PH_K2,
      PH_H,
      PH_F
   } phase_type;

   typedef enum logic [2:0] {
      OPND_LEN,
      OPND_WORD,
      OPND_XS_ACC,
      OPND_HASH_ACC,
      OPND_HASH_PART,
      OPND_XS_HASH
   } opnd_sel_type;

   typedef enum logic [1:0] {
      MSTEP_LL,
      MSTEP_LH,
      MSTEP_HL
   } mul_step_type;

   typedef enum logic {
      HASH_SEED_ACC,
      HASH_ACC
   } hash_sel_type;

   typedef struct packed {
      logic         capture;
      logic         opnd_load;
      opnd_sel_type opnd_sel;
      logic         mul_en;
      mul_step_type mul_step;
      logic         hash_load;
      hash_sel_type hash_sel;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full_word;
      logic part_word;
      logic last;
      logic rsp_free;
   } status_type;

endpackage

// ===== design/murmur_hash_64a_unit.sv =====
// A full word goes through three chained 64-bit multiplies, a 1 to 7 byte tail through one;
// the first word of a message adds a multiply of the length, and the last word (or an empty
// tail, alone) ends with the final multiply before its hash is shown, later while the previous
// hash still waits to be taken. Each multiply makes three passes through one shared 32x32
// multiplier, and the unit takes no new word until the current one is mixed in.
// Reset (synchronous, active high) clears the sequencer, the result valid and the seed.
`timescale 1ns / 1ps

// Top level of the 64-bit murmur hash unit: seed register on the APB-style port,
// sequencer and datapath. Depends on mh64_pkg, mh64_ctrl and mh64_datapath.
module murmur_hash_64a_unit (
   input  logic        clock,
   input  logic        reset,
   // message words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   input  logic [30:0] req_message_length,
   // finished hashes
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mh64_pkg::*;

   logic [31:0] seed_ff;
   logic        seed_wr;
   cmd_type     cmd;
   status_type  status;

   // Seed register: the user must write it only between messages, which the block itself does
   // not enforce; a new value applies from the next first word onwards.
   assign pready  = 1'b1;
   assign seed_wr = psel && penable && pwrite && (paddr == ADDR_HASH_SEED);
   assign prdata  = (paddr == ADDR_HASH_SEED) ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else if (seed_wr) begin
         seed_ff <= pwdata;
      end
   end

   // Sequencer: one word at a time, hold req_stall until the word is mixed in.
   mh64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: multiplier, running hash and the output word register, which
   // lets a finished hash wait while the next message is accepted.
   mh64_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .hash_seed          (seed_ff),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hash_value     (rsp_hash_value)
   );

endmodule

// ===== design/mh64_ctrl.sv =====
// Sequencer for the murmur hash unit: walks each word through the shared multiplier.
// Depends on mh64_pkg.
`timescale 1ns / 1ps

module mh64_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mh64_pkg::status_type status,
   output mh64_pkg::cmd_type    cmd
);
   import mh64_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      in_msg_ff, in_msg_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_INIT;
         in_msg_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         in_msg_ff <= in_msg_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = in_msg_ff ? ST_DISPATCH : ST_START;
            end
         end
         ST_START:    state_in = ST_MUL0;
         ST_DISPATCH: state_in = ST_MUL0;
         ST_MUL0:     state_in = ST_MUL1;
         ST_MUL1:     state_in = ST_MUL2;
         ST_MUL2:     state_in = ST_POST;
         ST_POST: begin
            case (phase_ff)
               PH_INIT: state_in = ST_DISPATCH;
               PH_K1:   state_in = ST_MUL0;
               PH_K2:   state_in = ST_MUL0;
               PH_H:    state_in = status.last ? ST_MUL0 : ST_IDLE;
               PH_F:    state_in = ST_EMIT;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      phase_in  = phase_ff;
      in_msg_in = in_msg_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
         end
         ST_START: begin
            cmd.opnd_load = 1'b1;
            cmd.opnd_sel  = OPND_LEN;
            phase_in      = PH_INIT;
         end
         ST_DISPATCH: begin
            cmd.opnd_load = 1'b1;
            if (status.full_word) begin
               cmd.opnd_sel = OPND_WORD;
               phase_in     = PH_K1;
            end else if (status.part_word) begin
               cmd.opnd_sel = OPND_HASH_PART;
               phase_in     = PH_H;
            end else begin
               cmd.opnd_sel = OPND_XS_HASH;
               phase_in     = PH_F;
            end
         end
         ST_MUL0: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MSTEP_LL;
         end
         ST_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MSTEP_LH;
         end
         ST_MUL2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MSTEP_HL;
         end
         ST_POST: begin
            case (phase_ff)
               PH_INIT: begin
                  cmd.hash_load = 1'b1;
                  cmd.hash_sel  = HASH_SEED_ACC;
                  in_msg_in     = 1'b1;
               end
               PH_K1: begin
                  cmd.opnd_load = 1'b1;
                  cmd.opnd_sel  = OPND_XS_ACC;
                  phase_in      = PH_K2;
               end
               PH_K2: begin
                  cmd.opnd_load = 1'b1;
                  cmd.opnd_sel  = OPND_HASH_ACC;
                  phase_in      = PH_H;
               end
               PH_H: begin
                  cmd.hash_load = 1'b1;
                  cmd.hash_sel  = HASH_ACC;
                  if (status.last) begin
                     cmd.opnd_load = 1'b1;
                     cmd.opnd_sel  = OPND_XS_ACC;
                     phase_in      = PH_F;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               in_msg_in    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/mh64_datapath.sv =====
// Datapath of the murmur hash unit: word capture, shared 32x32 multiplier,
// running hash and result register. Depends on mh64_pkg.
`timescale 1ns / 1ps

module mh64_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mh64_pkg::cmd_type    cmd,
   output mh64_pkg::status_type status,
   input  logic [31:0]          hash_seed,
   input  logic [63:0]          req_data_word,
   input  logic [3:0]           req_byte_count,
   input  logic                 req_last_word,
   input  logic [30:0]          req_message_length,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_hash_value
);
   import mh64_pkg::*;

   logic [63:0] word_ff;
   logic [3:0]  count_ff;
   logic        last_ff;
   logic [30:0] len_ff;
   logic [63:0] opnd_ff, opnd_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] rsp_hash_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod, term;
   logic [63:0] part_mask;
   logic [63:0] acc_xs;

   assign acc_xs    = acc_ff ^ (acc_ff >> MIX_SHIFT);
   assign part_mask = (64'd1 << {count_ff[2:0], 3'b000}) - 64'd1;

   always_comb begin
      case (cmd.opnd_sel)
         OPND_LEN:       opnd_in = {33'b0, len_ff};
         OPND_WORD:      opnd_in = word_ff;
         OPND_XS_ACC:    opnd_in = acc_xs;
         OPND_HASH_ACC:  opnd_in = hash_ff ^ acc_ff;
         OPND_HASH_PART: opnd_in = hash_ff ^ (word_ff & part_mask);
         OPND_XS_HASH:   opnd_in = hash_ff ^ (hash_ff >> MIX_SHIFT);
         default:        opnd_in = opnd_ff;
      endcase
   end

   // low 64 bits of opnd * MIX_MUL from three 32x32 partial products
   always_comb begin
      case (cmd.mul_step)
         MSTEP_LL: begin
            mul_a = opnd_ff[31:0];
            mul_b = MIX_MUL[31:0];
         end
         MSTEP_LH: begin
            mul_a = opnd_ff[31:0];
            mul_b = MIX_MUL[63:32];
         end
         MSTEP_HL: begin
            mul_a = opnd_ff[63:32];
            mul_b = MIX_MUL[31:0];
         end
         default: begin
            mul_a = opnd_ff[31:0];
            mul_b = MIX_MUL[31:0];
         end
      endcase
   end

   assign prod   = {32'b0, mul_a} * {32'b0, mul_b};
   assign term   = (cmd.mul_step == MSTEP_LL) ? prod : {prod[31:0], 32'b0};
   assign acc_in = ((cmd.mul_step == MSTEP_LL) ? 64'd0 : acc_ff) + term;

   assign hash_in = (cmd.hash_sel == HASH_SEED_ACC) ? ({32'b0, hash_seed} ^ acc_ff) : acc_ff;

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff  <= req_data_word;
         count_ff <= req_byte_count;
         last_ff  <= req_last_word;
         len_ff   <= req_message_length;
      end
      if (cmd.opnd_load) begin
         opnd_ff <= opnd_in;
      end
      if (cmd.mul_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.hash_load) begin
         hash_ff <= hash_in;
      end
      if (cmd.rsp_load) begin
         rsp_hash_ff <= acc_xs;
      end
   end

   assign status.full_word = !last_ff || count_ff[3];
   assign status.part_word = (count_ff[2:0] != 3'd0);
   assign status.last      = last_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

// ===== design/mh64_checker.sv =====
// Port-level checks for the murmur hash unit, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mh64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_hash_value
);

   // a held result word stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_hash_value))
   // one word at a time: the input stalls right after an accepted word
   `ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall)
   // no hash can appear the cycle after a word is taken
   `ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !$rose(rsp_valid))

endmodule

bind murmur_hash_64a_unit mh64_checker u_mh64_checker (.*);
